/* hdl/chub_pkg.sv */
// ----------------------------------------------------------------------------
// chub_pkg
// Shared types and constants for the colour histogram block.
// ----------------------------------------------------------------------------
package chub_pkg;

  localparam int LANES  = 8;
  localparam int LANE_W = 3;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_PIXEL = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef enum logic [2:0] {
    K_START,
    K_HIT,
    K_NEW,
    K_FULL,
    K_READ,
    K_READ_MISS,
    K_NONE
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CNT_RD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic  load;
    logic  search;
    logic  hit_latch;
    logic  cnt_rd;
    logic  emit;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_act;
    logic       rd_ok;
    logic       hit;
    logic       search_done;
    logic       room;
    logic       out_free;
  } status_t;

endpackage

/* hdl/color_histogram_uniform_block_top.sv */
// ----------------------------------------------------------------------------
// color_histogram_uniform_block_top
// Colour histogram with uniform 3x3 block marking.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A pixel searches the colour table eight
// entries a cycle from eight banked table RAMs, pipelined one row per cycle:
// the search stops on a hit or once every used entry is compared. Start,
// read and unknown actions skip the search. A stalled output holds back the
// next result. A result waits in the output register while the next beat
// is accepted. image_width should be written only while the block is
// idle (the block does not enforce this); no clearing pass is needed after reset or start.
// ----------------------------------------------------------------------------
module color_histogram_uniform_block_top #(
  parameter int MAX_COLORS = 256,
  parameter int MAX_WIDTH  = 4096,
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] pixel_color,
  input  logic [7:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  entry_index,
  output logic [31:0] entry_color,
  output logic [23:0] entry_count,
  output logic        entry_kept,
  output logic        new_entry,
  output logic        table_full,
  output logic        entry_valid,
  output logic [8:0]  colors_used
);
  import chub_pkg::*;

  cmd_t    cmd;
  status_t st;

  chub_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  chub_dp #(
    .MAX_COLORS (MAX_COLORS),
    .MAX_WIDTH  (MAX_WIDTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .action      (action),
    .pixel_color (pixel_color),
    .read_index  (read_index),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .entry_index (entry_index),
    .entry_color (entry_color),
    .entry_count (entry_count),
    .entry_kept  (entry_kept),
    .new_entry   (new_entry),
    .table_full  (table_full),
    .entry_valid (entry_valid),
    .colors_used (colors_used)
  );

endmodule

/* hdl/chub_ram.sv */
// ----------------------------------------------------------------------------
// chub_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chub_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/chub_ctrl.sv */
// ----------------------------------------------------------------------------
// chub_ctrl
// Sequencer: accepts a beat, runs the table search and issues the result.
// ----------------------------------------------------------------------------
module chub_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  chub_pkg::status_t st,
  output chub_pkg::cmd_t    cmd
);
  import chub_pkg::*;

  state_t state, state_next;
  kind_t  kind, kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= K_NONE;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  always_comb begin
    state_next    = state;
    kind_next     = kind;
    cmd           = '0;
    cmd.kind      = kind;
    in_ready      = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_EMIT;
          case (st.in_act)
            ACT_START: kind_next = K_START;
            ACT_PIXEL: state_next = S_SEARCH;
            ACT_READ:  kind_next = st.rd_ok ? K_READ : K_READ_MISS;
            default:   kind_next = K_NONE;
          endcase
        end
      end
      S_SEARCH: begin
        if (st.hit) begin
          cmd.hit_latch = 1'b1;
          state_next    = S_CNT_RD;
        end else if (st.search_done) begin
          kind_next  = st.room ? K_NEW : K_FULL;
          state_next = S_EMIT;
        end else begin
          cmd.search = 1'b1;
        end
      end
      S_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        kind_next  = K_HIT;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* hdl/chub_dp.sv */
// ----------------------------------------------------------------------------
// chub_dp
// Datapath: banked colour table, count store, row buffers, window, output.
// ----------------------------------------------------------------------------
module chub_dp #(
  parameter int MAX_COLORS = 256,
  parameter int MAX_WIDTH  = 4096,
  parameter int COUNT_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [12:0]       cfg_wr_data,
  input  logic [1:0]        action,
  input  logic [31:0]       pixel_color,
  input  logic [7:0]        read_index,
  input  chub_pkg::cmd_t    cmd,
  output chub_pkg::status_t st,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        entry_index,
  output logic [31:0]       entry_color,
  output logic [23:0]       entry_count,
  output logic              entry_kept,
  output logic              new_entry,
  output logic              table_full,
  output logic              entry_valid,
  output logic [8:0]        colors_used
);
  import chub_pkg::*;

  localparam int IDX_W  = $clog2(MAX_COLORS);
  localparam int USED_W = $clog2(MAX_COLORS + 1);
  localparam int BANK_D = (MAX_COLORS + LANES - 1) / LANES;
  localparam int BA_W   = BANK_D > 1 ? $clog2(BANK_D) : 1;
  localparam int COL_W  = $clog2(MAX_WIDTH);

  logic [12:0]       image_width;
  logic [USED_W-1:0] used;
  logic [COL_W-1:0]  col;
  logic [1:0]        row;
  logic [31:0]       left0, left1, ul0, ul1, u2l0, u2l1;
  logic [31:0]       pix;
  logic [7:0]        ridx;
  logic [BA_W:0]     row_cnt;
  logic [BA_W:0]     cmp_row;
  logic              cmp_vld;
  logic [IDX_W-1:0]  hit_idx;

  logic [31:0]       bank_rdata [LANES];
  logic [LANES-1:0]  bank_we;
  logic [BA_W-1:0]   bank_raddr, bank_waddr;
  logic              bank_re;
  logic [COUNT_BITS:0] cram_rdata, cram_wdata;
  logic [IDX_W-1:0]  cram_raddr, cram_waddr;
  logic              cram_re, cram_we;
  logic [31:0]       ra_rdata, rb_rdata;
  logic              row_we;

  logic [31:0]       used32, ridx32, eff_w;
  logic              issuing, pixel_kind, uniform;
  logic              hit_any;
  logic [IDX_W-1:0]  hit_found;
  logic [COUNT_BITS-1:0] cnt_old, cnt_new;
  logic              kept_new;
  logic [31:0]       cnt32;

  assign used32 = 32'(used);
  assign ridx32 = 32'(ridx);

  assign issuing    = cmd.search && ((32'(row_cnt) << LANE_W) < used32);
  assign pixel_kind = cmd.kind == K_HIT || cmd.kind == K_NEW || cmd.kind == K_FULL;

  always_comb begin
    hit_any   = 1'b0;
    hit_found = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (cmp_vld && bank_rdata[l] == pix &&
          ((32'(cmp_row) << LANE_W) + 32'(l)) < used32) begin
        hit_any   = 1'b1;
        hit_found = IDX_W'((32'(cmp_row) << LANE_W) + 32'(l));
      end
    end
  end

  always_comb begin
    st.in_act      = action;
    st.rd_ok       = 32'(read_index) < used32;
    st.hit         = hit_any;
    st.search_done = !cmp_vld && ((32'(row_cnt) << LANE_W) >= used32);
    st.room        = used32 < 32'(MAX_COLORS);
    st.out_free    = !out_valid || out_ready;
  end

  // table banks
  assign bank_re    = issuing || (cmd.load && action == ACT_READ);
  assign bank_raddr = cmd.load ? BA_W'(32'(read_index) >> LANE_W) : BA_W'(row_cnt);
  assign bank_waddr = BA_W'(used32 >> LANE_W);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      bank_we[l] = cmd.emit && cmd.kind == K_NEW && used32[LANE_W-1:0] == LANE_W'(l);
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_bank
    chub_ram #(.WIDTH(32), .DEPTH(BANK_D)) u_bank (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (bank_waddr),
      .wdata (pix),
      .re    (bank_re),
      .raddr (bank_raddr),
      .rdata (bank_rdata[g])
    );
  end

  // counts and keep flags
  assign cram_re    = cmd.cnt_rd || (cmd.load && action == ACT_READ);
  assign cram_raddr = cmd.cnt_rd ? hit_idx : IDX_W'(read_index);
  assign cnt_old    = cram_rdata[COUNT_BITS-1:0];
  assign cnt_new    = (&cnt_old) ? cnt_old : cnt_old + COUNT_BITS'(1);
  assign kept_new   = cram_rdata[COUNT_BITS] | uniform;
  assign cram_we    = cmd.emit && (cmd.kind == K_HIT || cmd.kind == K_NEW);
  assign cram_waddr = cmd.kind == K_HIT ? hit_idx : IDX_W'(used);
  assign cram_wdata = cmd.kind == K_HIT ? {kept_new, cnt_new} : {1'b0, COUNT_BITS'(1)};

  chub_ram #(.WIDTH(COUNT_BITS + 1), .DEPTH(MAX_COLORS)) u_cnt (
    .clk   (clk),
    .we    (cram_we),
    .waddr (cram_waddr),
    .wdata (cram_wdata),
    .re    (cram_re),
    .raddr (cram_raddr),
    .rdata (cram_rdata)
  );

  // row buffers
  assign row_we = cmd.emit && pixel_kind;

  chub_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_row_a (
    .clk   (clk),
    .we    (row_we),
    .waddr (col),
    .wdata (pix),
    .re    (cmd.load && action == ACT_PIXEL),
    .raddr (col),
    .rdata (ra_rdata)
  );

  chub_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_row_b (
    .clk   (clk),
    .we    (row_we),
    .waddr (col),
    .wdata (ra_rdata),
    .re    (cmd.load && action == ACT_PIXEL),
    .raddr (col),
    .rdata (rb_rdata)
  );

  assign uniform = col >= COL_W'(2) && row >= 2'd2 &&
                   left0 == pix && left1 == pix && ra_rdata == pix &&
                   ul0 == pix && ul1 == pix && rb_rdata == pix &&
                   u2l0 == pix && u2l1 == pix;

  always_comb begin
    eff_w = 32'(image_width);
    if (eff_w == 32'd0) eff_w = 32'd1;
    if (eff_w > 32'(MAX_WIDTH)) eff_w = 32'(MAX_WIDTH);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix  <= pixel_color;
      ridx <= read_index;
    end
    if (cmd.hit_latch) begin
      hit_idx <= hit_found;
    end
    if (cmd.load) begin
      row_cnt <= '0;
    end else if (issuing) begin
      row_cnt <= row_cnt + 1'b1;
    end
    cmp_row <= row_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 13'd640;
      used        <= '0;
      col         <= '0;
      row         <= '0;
      left0       <= '0;
      left1       <= '0;
      ul0         <= '0;
      ul1         <= '0;
      u2l0        <= '0;
      u2l1        <= '0;
      cmp_vld     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        image_width <= cfg_wr_data;
      end
      cmp_vld <= issuing;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit && cmd.kind == K_START) begin
        used  <= '0;
        col   <= '0;
        row   <= '0;
        left0 <= '0;
        left1 <= '0;
        ul0   <= '0;
        ul1   <= '0;
        u2l0  <= '0;
        u2l1  <= '0;
      end
      if (cmd.emit && cmd.kind == K_NEW) begin
        used <= used + 1'b1;
      end
      if (row_we) begin
        u2l1  <= u2l0;
        u2l0  <= rb_rdata;
        ul1   <= ul0;
        ul0   <= ra_rdata;
        left1 <= left0;
        left0 <= pix;
        if (32'(col) + 32'd1 >= eff_w) begin
          col <= '0;
          if (row != 2'd2) begin
            row <= row + 2'd1;
          end
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  assign cnt32 = 32'(cram_rdata[COUNT_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      entry_index <= '0;
      entry_color <= '0;
      entry_count <= '0;
      entry_kept  <= 1'b0;
      new_entry   <= 1'b0;
      table_full  <= 1'b0;
      entry_valid <= 1'b0;
      colors_used <= 9'(used32);
      case (cmd.kind)
        K_START: colors_used <= '0;
        K_HIT: begin
          entry_index <= 8'(32'(hit_idx));
          entry_color <= pix;
          entry_count <= 24'(32'(cnt_new));
          entry_kept  <= kept_new;
          entry_valid <= 1'b1;
        end
        K_NEW: begin
          entry_index <= 8'(used32);
          entry_color <= pix;
          entry_count <= 24'd1;
          new_entry   <= 1'b1;
          entry_valid <= 1'b1;
          colors_used <= 9'(used32 + 32'd1);
        end
        K_FULL: begin
          entry_color <= pix;
          table_full  <= 1'b1;
        end
        K_READ: begin
          entry_index <= ridx;
          entry_color <= bank_rdata[ridx32[LANE_W-1:0]];
          entry_count <= cnt32[23:0];
          entry_kept  <= cram_rdata[COUNT_BITS];
          entry_valid <= 1'b1;
        end
        K_READ_MISS: entry_index <= ridx;
        default: ;
      endcase
    end
  end

endmodule

/* verif/chub_checker.sv */
// ----------------------------------------------------------------------------
// chub_checker
// Watches both channels of the colour histogram block, predicts every beat
// out from the beats in and the width register, and compares field by field.
// ----------------------------------------------------------------------------
module chub_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] pixel_color,
  input  logic [7:0]  read_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  entry_index,
  input  logic [31:0] entry_color,
  input  logic [23:0] entry_count,
  input  logic        entry_kept,
  input  logic        new_entry,
  input  logic        table_full,
  input  logic        entry_valid,
  input  logic [8:0]  colors_used,
  output int          fail_count,
  output int          pending,
  output int          kept_seen,
  output int          full_seen
);
  import chub_pkg::*;

  localparam int NCOL = 256;
  localparam int WMAX = 4096;
  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [7:0]  idx;
    logic [31:0] color;
    logic [23:0] count;
    logic        kept;
    logic        fresh;
    logic        full;
    logic        valid;
    logic [8:0]  used;
  } entry_beat_t;

  logic [12:0] width_reg;
  logic [31:0] hist_color [NCOL];
  logic [23:0] hist_count [NCOL];
  logic        hist_kept  [NCOL];
  logic [8:0]  hist_used;
  logic [31:0] line1 [WMAX];
  logic [31:0] line2 [WMAX];
  logic [31:0] left0, left1, up0, up1, upup0, upup1;
  int          col_pos, row_pos;
  entry_beat_t expected_beats [$];

  task automatic clear_image();
    for (int i = 0; i < NCOL; i++) begin
      hist_color[i] = '0;
      hist_count[i] = '0;
      hist_kept[i]  = 1'b0;
    end
    for (int i = 0; i < WMAX; i++) begin
      line1[i] = '0;
      line2[i] = '0;
    end
    {left0, left1, up0, up1, upup0, upup1} = '0;
    hist_used = '0;
    col_pos   = 0;
    row_pos   = 0;
  endtask

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > WMAX) return WMAX;
    return int'(width_reg);
  endfunction

  task automatic predict_beat(input logic [1:0] act, input logic [31:0] pix,
                              input logic [7:0] ridx, output entry_beat_t r);
    int          c, hit;
    logic [31:0] a, b;
    logic        uniform, found;
    r = '0;
    if (act == ACT_START) begin
      clear_image();
    end else if (act == ACT_PIXEL) begin
      c = (col_pos >= WMAX) ? WMAX - 1 : col_pos;
      a = line1[c];
      b = line2[c];
      uniform = c >= 2 && row_pos >= 2 && left0 == pix && left1 == pix && a == pix &&
                up0 == pix && up1 == pix && b == pix && upup0 == pix && upup1 == pix;
      found = 1'b0;
      hit   = 0;
      for (int i = 0; i < hist_used; i++) begin
        if (!found && hist_color[i] == pix) begin
          found = 1'b1;
          hit   = i;
        end
      end
      if (found) begin
        if (hist_count[hit] < CNT_MAX) hist_count[hit]++;
        if (uniform) hist_kept[hit] = 1'b1;
      end else if (hist_used < NCOL) begin
        hit = hist_used;
        hist_color[hit] = pix;
        hist_count[hit] = 24'd1;
        hist_kept[hit]  = 1'b0;
        hist_used++;
        r.fresh = 1'b1;
      end
      if (found || r.fresh) begin
        r.idx   = hit[7:0];
        r.color = hist_color[hit];
        r.count = hist_count[hit];
        r.kept  = hist_kept[hit];
        r.valid = 1'b1;
      end else begin
        r.color = pix;
        r.full  = 1'b1;
      end
      upup1 = upup0;
      upup0 = b;
      up1   = up0;
      up0   = a;
      line2[c] = a;
      line1[c] = pix;
      left1 = left0;
      left0 = pix;
      if (c + 1 >= eff_width()) begin
        col_pos = 0;
        if (row_pos < 2) row_pos++;
      end else begin
        col_pos = c + 1;
      end
    end else if (act == ACT_READ) begin
      r.idx = ridx;
      if (ridx < hist_used) begin
        r.color = hist_color[ridx];
        r.count = hist_count[ridx];
        r.kept  = hist_kept[ridx];
        r.valid = 1'b1;
      end
    end
    r.used = hist_used;
  endtask

  function automatic int check_field(string name, longint exp_v, longint got_v);
    if (exp_v == got_v) return 0;
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, got_v);
    return 1;
  endfunction

  assign pending = expected_beats.size();

  always @(posedge clk) begin
    entry_beat_t e;
    int          errs;
    if (rst) begin
      width_reg  = 13'd640;
      fail_count = 0;
      kept_seen  = 0;
      full_seen  = 0;
      clear_image();
      expected_beats.delete();
    end else begin
      if (cfg_wr_en) width_reg = cfg_wr_data;
      if (in_valid && in_ready) begin
        predict_beat(action, pixel_color, read_index, e);
        expected_beats.insert(expected_beats.size(), e);
      end
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat out, expected none actual colour %0h",
                   $time, entry_color);
          fail_count++;
        end else begin
          e = expected_beats.pop_front();
          if (e.kept) kept_seen++;
          if (e.full) full_seen++;
          errs = check_field("entry_index", e.idx, entry_index) +
                 check_field("entry_color", e.color, entry_color) +
                 check_field("entry_count", e.count, entry_count) +
                 check_field("entry_kept", e.kept, entry_kept) +
                 check_field("new_entry", e.fresh, new_entry) +
                 check_field("table_full", e.full, table_full) +
                 check_field("entry_valid", e.valid, entry_valid) +
                 check_field("colors_used", e.used, colors_used);
          if (errs != 0) fail_count++;
        end
      end
    end
  end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the colour histogram block: directed corner beats, then random
// images of mostly small widths with few colours so uniform 3x3 blocks occur,
// plus one image that overflows the colour table. Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import chub_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 1050;

  logic        clk, rst, cfg_wr_en, in_valid, in_ready, out_valid, out_ready;
  logic [12:0] cfg_wr_data;
  logic [1:0]  action;
  logic [31:0] pixel_color, entry_color;
  logic [7:0]  read_index, entry_index;
  logic [23:0] entry_count;
  logic        entry_kept, new_entry, table_full, entry_valid;
  logic [8:0]  colors_used;
  int          fail_count, pending, kept_seen, full_seen;
  int          beats_sent;
  bit          no_stall;

  color_histogram_uniform_block_top u_dut (.*);

  chub_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_beat(input logic [1:0] act, input logic [31:0] pix,
                           input logic [7:0] ridx);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    pixel_color <= pix;
    read_index  <= ridx;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if ($urandom_range(0, 60) == 0) no_stall = !no_stall;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_width(input logic [12:0] w);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // result side stalls independently
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [31:0] palette [4];
    logic [12:0] w;
    int          npix, nplt, pick;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    action = ACT_START;
    pixel_color = '0;
    read_index = '0;
    beats_sent = 0;
    no_stall = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every action, hit, miss reads, unused code
    send_beat(ACT_PIXEL, 32'h0000_0000, 8'd0);
    send_beat(ACT_PIXEL, 32'hFFFF_FFFF, 8'd0);
    send_beat(ACT_PIXEL, 32'h0000_0000, 8'd0);
    send_beat(ACT_PIXEL, 32'hAAAA_5555, 8'd0);
    send_beat(ACT_READ, 32'hFFFF_FFFF, 8'd0);
    send_beat(ACT_READ, 32'h0, 8'd1);
    send_beat(ACT_READ, 32'h0, 8'd3);
    send_beat(ACT_READ, 32'h0, 8'hFF);
    send_beat(ACT_UNUSED, 32'h5555_AAAA, 8'hAA);
    send_beat(ACT_START, 32'hFFFF_FFFF, 8'h55);
    send_beat(ACT_READ, 32'h0, 8'd0);
    // nine equal pixels on a 3-wide image close a uniform block
    set_width(13'd3);
    send_beat(ACT_START, 32'h0, 8'd0);
    repeat (9) send_beat(ACT_PIXEL, 32'h1234_5678, 8'd0);
    send_beat(ACT_READ, 32'h0, 8'd0);

    // table overflow
    set_width(13'd16);
    send_beat(ACT_START, 32'h0, 8'd0);
    for (int i = 0; i < 270; i++) send_beat(ACT_PIXEL, {i[15:0], 16'hC0DE}, 8'd0);
    send_beat(ACT_PIXEL, 32'h0000_C0DE, 8'd0);
    send_beat(ACT_READ, 32'h0, 8'd255);
    send_beat(ACT_READ, 32'h0, 8'd0);

    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0:       w = 13'd0;
        1:       w = 13'd4096;
        2:       w = 13'h1FFF;
        3:       w = 13'($urandom);
        default: w = 13'($urandom_range(1, 8));
      endcase
      set_width(w);
      send_beat(ACT_START, $urandom, 8'($urandom));
      nplt = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) palette[i] = $urandom;
      npix = (w >= 1 && w <= 8) ? int'(w) * $urandom_range(3, 7) : $urandom_range(5, 40);
      for (int i = 0; i < npix; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8)
          send_beat(ACT_READ, $urandom, ($urandom_range(0, 1) == 0) ?
                    8'($urandom_range(0, 4)) : 8'($urandom));
        else if (pick < 10)
          send_beat(ACT_UNUSED, $urandom, 8'($urandom));
        else if (pick < 11)
          send_beat(ACT_PIXEL, $urandom, 8'($urandom));
        else if (pick < 75)
          send_beat(ACT_PIXEL, palette[0], 8'($urandom));
        else
          send_beat(ACT_PIXEL, palette[$urandom_range(0, nplt - 1)], 8'($urandom));
      end
    end

    wait_idle();
    $display("Sent %0d random beats after the directed set; %0d kept results,", beats_sent,
             kept_seen);
    $display("%0d table-full results seen.", full_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
